@@ hdl/robot_feeder_controller_unit_macros.svh @@
// assertion macros shared by the checker of the feeder controller
`ifndef ROBOT_FEEDER_CONTROLLER_UNIT_MACROS_SVH
`define ROBOT_FEEDER_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfc check failed");

// next-cycle implication, disabled during reset
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfc check failed");

`endif

@@ hdl/rfc_pkg.sv @@
// constants shared by the feeder controller and its checker
package rfc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWER_SPD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_PER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_PER = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_DEBOUNCE   = 16'd50;
    localparam logic [7:0]  RST_OBSTACLE   = 8'd20;
    localparam logic [6:0]  RST_WATER_THR  = 7'd40;
    localparam logic [9:0]  RST_DRIVE_SPD  = 10'd900;
    localparam logic [9:0]  RST_DRAWER_SPD = 10'd700;
    localparam logic [15:0] RST_MOTION_PER = 16'd1000;
    localparam logic [15:0] RST_SENSE_PER  = 16'd1000;

    typedef logic [2:0] t_motion;

    // motion codes
    localparam t_motion MV_FWD   = 3'd0;
    localparam t_motion MV_BACK  = 3'd1;
    localparam t_motion MV_RIGHT = 3'd2;
    localparam t_motion MV_LEFT  = 3'd3;
    localparam t_motion MV_STOP  = 3'd4;

    // command characters
    localparam logic [7:0] CMD_FWD    = 8'h66; // f
    localparam logic [7:0] CMD_BACK   = 8'h62; // b
    localparam logic [7:0] CMD_LEFT   = 8'h6C; // l
    localparam logic [7:0] CMD_RIGHT  = 8'h72; // r
    localparam logic [7:0] CMD_AUTO   = 8'h61; // a
    localparam logic [7:0] CMD_GATE   = 8'h78; // x
    localparam logic [7:0] CMD_PUMP   = 8'h77; // w
    localparam logic [7:0] CMD_DRAWER = 8'h74; // t

    typedef logic signed [10:0] t_speed;

endpackage

@@ hdl/rfc_req_if.sv @@
// request channel of the feeder controller: one control loop tick
interface rfc_req_if;
    logic       valid;
    logic       ready;
    logic [31:0] now_ms;
    logic       cmd_valid;
    logic [7:0] cmd_char;
    logic [9:0] water_level;
    logic       limit_one;
    logic       limit_two;
    logic [7:0] dist_left;
    logic [7:0] dist_right;
    logic [7:0] dist_front;

    modport source (
        output valid, now_ms, cmd_valid, cmd_char, water_level,
               limit_one, limit_two, dist_left, dist_right, dist_front,
        input  ready
    );
    modport sink (
        input  valid, now_ms, cmd_valid, cmd_char, water_level,
               limit_one, limit_two, dist_left, dist_right, dist_front,
        output ready
    );
endinterface

@@ hdl/rfc_rsp_if.sv @@
// result channel of the feeder controller: actuator state after one tick
interface rfc_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        move_code;
    logic signed [10:0] left_speed;
    logic signed [10:0] right_speed;
    logic signed [10:0] drawer_motor_speed;
    logic              drawer_power;
    logic              gate_open;
    logic              pump_on;
    logic              auto_mode;

    modport source (
        output valid, move_code, left_speed, right_speed, drawer_motor_speed,
               drawer_power, gate_open, pump_on, auto_mode,
        input  ready
    );
    modport sink (
        input  valid, move_code, left_speed, right_speed, drawer_motor_speed,
               drawer_power, gate_open, pump_on, auto_mode,
        output ready
    );
endinterface

@@ hdl/robot_feeder_controller_unit.sv @@
// feeder robot controller: commands, interlocks, drawer debounce, auto drive
//
// usage
//   i_req carries one control loop tick per request: time, optional command
//   byte, water reading, raw drawer end switches and three sonar distances.
//   o_rsp returns exactly one result per request: motion code, wheel and
//   drawer speeds, relay, gate, pump and auto mode flags.
//   i_cfg_we / i_cfg_idx / i_cfg_wdata write the seven tuning registers; write
//   them only while no request is in flight.
// timing
//   a request is registered on acceptance and its result register is loaded
//   from it once the result register is empty or o_rsp.ready is high. one
//   request per cycle is sustained while o_rsp.ready stays high.
// stall
//   the input register and the result register are separate stages, so one
//   more request is taken while a result waits; i_req.ready drops only once
//   both stages are full and o_rsp.ready is low.
// reset
//   synchronous active low reset empties both stages, loads the register
//   defaults and returns the controller to stop with a drawer move pending.
module robot_feeder_controller_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    rfc_req_if.sink                        i_req,
    rfc_rsp_if.source                      o_rsp
);
    import rfc_pkg::*;

    // configuration
    logic [15:0] r_debounce;
    logic [7:0]  r_obstacle;
    logic [6:0]  r_water_thr;
    logic [9:0]  r_drive_spd;
    logic [9:0]  r_drawer_spd;
    logic [15:0] r_motion_per;
    logic [15:0] r_sense_per;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_now;
    logic        r_cmd_valid;
    logic [7:0]  r_cmd;
    logic [9:0]  r_water;
    logic [1:0]  r_limit;
    logic [7:0]  r_dl, r_dr, r_df;

    // controller state
    t_motion     r_motion, n_motion;
    t_motion     r_applied, n_applied;
    logic        r_auto, n_auto;
    logic        r_gate, n_gate;
    logic        r_pump, n_pump;
    logic        r_dreq, n_dreq;
    logic        r_done, n_done;
    logic        r_rev, n_rev;
    logic        r_running, n_running;
    logic        r_relay, n_relay;
    logic [1:0]  r_raw_last, n_raw_last;
    logic [1:0]  r_stable, n_stable;
    logic [31:0] r_change_time [2];
    logic [31:0] n_change_time [2];
    logic [31:0] r_motion_time, n_motion_time;
    logic [31:0] r_sense_time, n_sense_time;
    logic [7:0]  r_held [3];
    logic [7:0]  n_held [3];

    // result stage
    logic        r_out_valid;
    t_motion     r_out_motion;
    t_speed      r_out_left, r_out_right, r_out_drawer;
    logic        r_out_relay, r_out_gate, r_out_pump, r_out_auto;

    logic        w_adv;
    logic [16:0] w_level, w_thr;
    logic        w_drawer_act;
    logic [1:0]  w_ct_new;
    logic [1:0]  w_fire;
    logic [1:0]  w_rise;
    logic [31:0] w_ct [2];
    t_speed      w_drive_pos, w_drawer_pos;
    t_speed      n_left, n_right, n_drawer;

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    assign w_level      = 17'(r_water) * 17'd100;
    assign w_thr        = 17'(r_water_thr) * 17'd1023;
    assign w_drive_pos  = t_speed'({1'b0, r_drive_spd});
    assign w_drawer_pos = t_speed'({1'b0, r_drawer_spd});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= RST_DEBOUNCE;
            r_obstacle   <= RST_OBSTACLE;
            r_water_thr  <= RST_WATER_THR;
            r_drive_spd  <= RST_DRIVE_SPD;
            r_drawer_spd <= RST_DRAWER_SPD;
            r_motion_per <= RST_MOTION_PER;
            r_sense_per  <= RST_SENSE_PER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_wdata;
                CFG_OBSTACLE:   r_obstacle   <= i_cfg_wdata[7:0];
                CFG_WATER_THR:  r_water_thr  <= i_cfg_wdata[6:0];
                CFG_DRIVE_SPD:  r_drive_spd  <= i_cfg_wdata[9:0];
                CFG_DRAWER_SPD: r_drawer_spd <= i_cfg_wdata[9:0];
                CFG_MOTION_PER: r_motion_per <= i_cfg_wdata;
                CFG_SENSE_PER:  r_sense_per  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_now       <= i_req.now_ms;
            r_cmd_valid <= i_req.cmd_valid;
            r_cmd       <= i_req.cmd_char;
            r_water     <= i_req.water_level;
            r_limit     <= {i_req.limit_two, i_req.limit_one};
            r_dl        <= i_req.dist_left;
            r_dr        <= i_req.dist_right;
            r_df        <= i_req.dist_front;
        end
    end

    // switch debounce terms, used only while the drawer section is active
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_ct_new[i] = r_limit[i] != r_raw_last[i];
            w_ct[i]     = w_ct_new[i] ? r_now : r_change_time[i];
            w_fire[i]   = ((r_now - w_ct[i]) > 32'(r_debounce))
                          && (r_limit[i] != r_stable[i]);
            w_rise[i]   = w_fire[i] && r_limit[i];
        end
    end

    always_comb begin
        n_motion      = r_motion;
        n_applied     = r_applied;
        n_auto        = r_auto;
        n_gate        = r_gate;
        n_pump        = r_pump;
        n_dreq        = r_dreq;
        n_done        = r_done;
        n_rev         = r_rev;
        n_running     = r_running;
        n_relay       = r_relay;
        n_raw_last    = r_raw_last;
        n_stable      = r_stable;
        n_change_time = r_change_time;
        n_motion_time = r_motion_time;
        n_sense_time  = r_sense_time;
        n_held        = r_held;

        if (r_cmd_valid) begin
            n_sense_time = r_now;
            unique case (r_cmd)
                CMD_FWD: begin
                    n_motion = MV_FWD;
                    n_auto   = 1'b0;
                end
                CMD_BACK: begin
                    n_motion = MV_BACK;
                    n_auto   = 1'b0;
                end
                CMD_LEFT: begin
                    n_motion = MV_LEFT;
                    n_auto   = 1'b0;
                end
                CMD_RIGHT: begin
                    n_motion = MV_RIGHT;
                    n_auto   = 1'b0;
                end
                CMD_AUTO: n_auto = 1'b1;
                CMD_GATE: n_gate = !r_gate && !r_dreq;
                CMD_PUMP: begin
                    if (!r_pump && !r_dreq) begin
                        if (w_level < w_thr) begin
                            n_pump = 1'b1;
                        end
                    end else begin
                        n_pump = 1'b0;
                    end
                end
                CMD_DRAWER: begin
                    if (!r_pump && !r_gate) begin
                        n_dreq = !r_dreq;
                    end
                end
                default: begin
                    n_motion = MV_STOP;
                    n_auto   = 1'b0;
                end
            endcase
        end

        // tank too full forces the pump off
        if (w_level > w_thr) begin
            n_pump = 1'b0;
        end

        // drawer move is pending and the robot is stopped
        w_drawer_act = (r_done != n_dreq) && (n_motion == MV_STOP);
        if (w_drawer_act) begin
            for (int i = 0; i < 2; i++) begin
                n_change_time[i] = w_ct[i];
                if (w_fire[i]) begin
                    n_stable[i] = r_limit[i];
                end
            end
            n_raw_last = r_limit;
            // each confirmed high reverses once, so both together cancel
            n_rev      = r_rev ^ w_rise[0] ^ w_rise[1];
            n_done     = (|w_rise) ? n_dreq : r_done;
            n_running  = n_done != n_dreq;
            n_relay    = n_done != n_dreq;
        end

        if (n_auto) begin
            if ((r_now - n_sense_time) >= 32'(r_sense_per)) begin
                n_sense_time = r_now;
                n_held[0]    = r_dl;
                n_held[1]    = r_dr;
                n_held[2]    = r_df;
            end
            if (n_held[2] > r_obstacle) begin
                n_motion = MV_FWD;
            end else if (n_held[0] > n_held[1]) begin
                n_motion = (n_held[0] > r_obstacle) ? MV_LEFT : MV_STOP;
            end else begin
                n_motion = (n_held[1] > r_obstacle) ? MV_RIGHT : MV_STOP;
            end
        end

        if ((r_now - r_motion_time) >= 32'(r_motion_per)) begin
            n_motion_time = r_now;
            n_applied     = n_motion;
        end

        unique case (n_applied)
            MV_FWD: begin
                n_left  = w_drive_pos;
                n_right = w_drive_pos;
            end
            MV_BACK: begin
                n_left  = -w_drive_pos;
                n_right = -w_drive_pos;
            end
            MV_RIGHT: begin
                n_left  = w_drive_pos;
                n_right = -w_drive_pos;
            end
            MV_LEFT: begin
                n_left  = -w_drive_pos;
                n_right = w_drive_pos;
            end
            default: begin
                n_left  = '0;
                n_right = '0;
            end
        endcase

        if (n_running) begin
            n_drawer = n_rev ? -w_drawer_pos : w_drawer_pos;
        end else begin
            n_drawer = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion         <= MV_STOP;
            r_applied        <= MV_STOP;
            r_auto           <= 1'b0;
            r_gate           <= 1'b0;
            r_pump           <= 1'b0;
            r_dreq           <= 1'b0;
            r_done           <= 1'b1;
            r_rev            <= 1'b0;
            r_running        <= 1'b0;
            r_relay          <= 1'b0;
            r_raw_last       <= '0;
            r_stable         <= '0;
            r_change_time[0] <= '0;
            r_change_time[1] <= '0;
            r_motion_time    <= '0;
            r_sense_time     <= '0;
            r_held[0]        <= '0;
            r_held[1]        <= '0;
            r_held[2]        <= '0;
        end else if (w_adv) begin
            r_motion      <= n_motion;
            r_applied     <= n_applied;
            r_auto        <= n_auto;
            r_gate        <= n_gate;
            r_pump        <= n_pump;
            r_dreq        <= n_dreq;
            r_done        <= n_done;
            r_rev         <= n_rev;
            r_running     <= n_running;
            r_relay       <= n_relay;
            r_raw_last    <= n_raw_last;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_motion_time <= n_motion_time;
            r_sense_time  <= n_sense_time;
            r_held        <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_motion <= n_motion;
            r_out_left   <= n_left;
            r_out_right  <= n_right;
            r_out_drawer <= n_drawer;
            r_out_relay  <= n_relay;
            r_out_gate   <= n_gate;
            r_out_pump   <= n_pump;
            r_out_auto   <= n_auto;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.move_code          = r_out_motion;
    assign o_rsp.left_speed         = r_out_left;
    assign o_rsp.right_speed        = r_out_right;
    assign o_rsp.drawer_motor_speed = r_out_drawer;
    assign o_rsp.drawer_power       = r_out_relay;
    assign o_rsp.gate_open          = r_out_gate;
    assign o_rsp.pump_on            = r_out_pump;
    assign o_rsp.auto_mode          = r_out_auto;

endmodule

@@ hdl/rfc_checker.sv @@
// port level checks of the feeder controller and their binding
`include "robot_feeder_controller_unit_macros.svh"

module rfc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input rfc_pkg::t_motion  i_move_code,
    input rfc_pkg::t_speed   i_left_speed,
    input rfc_pkg::t_speed   i_right_speed,
    input rfc_pkg::t_speed   i_drawer_speed,
    input logic              i_drawer_power
);
    import rfc_pkg::*;

    // a held result keeps its motion code and left speed
    `RFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_move_code) && $stable(i_left_speed))

    // requests are refused only while both stages are full and the result is stuck
    `RFC_ASSERT_IMP(a_in_stall, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    `RFC_ASSERT_IMP(a_move_range, i_clk, i_rst_n, i_out_valid, i_move_code <= MV_STOP)

    // a turning drawer stepper always has its relay energised
    `RFC_ASSERT_IMP(a_drawer_relay, i_clk, i_rst_n, i_out_valid && (i_drawer_speed != 11'sd0), i_drawer_power)

    // both sides share one magnitude
    `RFC_ASSERT_IMP(a_wheel_pair, i_clk, i_rst_n, i_out_valid, (i_left_speed == i_right_speed) || ((i_left_speed + i_right_speed) == 11'sd0))

endmodule

bind robot_feeder_controller_unit rfc_checker u_rfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_move_code    (o_rsp.move_code),
    .i_left_speed   (o_rsp.left_speed),
    .i_right_speed  (o_rsp.right_speed),
    .i_drawer_speed (o_rsp.drawer_motor_speed),
    .i_drawer_power (o_rsp.drawer_power)
);
